// ===== hdl/tcce_pkg.sv =====
// Types and constants shared by the text console cursor engine.
// Command and result transfer structs, function and result codes.
// No dependencies.
package tcce_pkg;

	localparam int ADDR_W = 11;

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_CURSOR = 2'd3
	} kind_t;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [7:0] ATTR_RESET = 8'h0F;

	typedef struct packed {
		func_t      func;
		logic [7:0] char_code;
		logic [6:0] new_col;
		logic [4:0] new_row;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] cell_address;
		logic [15:0]       cell_value;
		logic [6:0]        cursor_col_out;
		logic [4:0]        cursor_row_out;
		logic              last;
	} res_t;

	// Slot 0 cell write, slot 1 scroll or clear, slot 2 cursor update.
	typedef struct packed {
		logic [2:0]     valid;
		res_t [2:0]     slot;
	} bundle_t;

endpackage

// ===== hdl/tcce_decode.sv =====
// Command decode for the text console cursor engine.
// Works out the result slots and the next cursor for one command.
// Depends on tcce_pkg.
module tcce_decode import tcce_pkg::*; #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  cmd_t       cmd,
	input  logic [6:0] col,
	input  logic [4:0] row,
	input  logic [7:0] attr,
	output bundle_t    bundle,
	output logic [6:0] next_col,
	output logic [4:0] next_row
);

	localparam int STOPS = COLUMNS / TAB_WIDTH + 1;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [5:0] r, input logic [7:0] c);
		logic [31:0] full;
		full = 32'(r) * 32'(COLUMNS) + 32'(c);
		return full[ADDR_W-1:0];
	endfunction

	logic [7:0]  c;
	logic [5:0]  r;
	logic [7:0]  tab_c;
	logic        wr_en;
	logic        sc_en;
	kind_t       sc_kind;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] sc_addr;
	logic [15:0] wr_val;
	logic [15:0] blank;

	assign blank = {attr, CH_SPACE};

	// next tab stop strictly beyond the current column
	always_comb begin
		tab_c = '0;
		for (int k = STOPS; k >= 1; k--) begin
			if (8'(k * TAB_WIDTH) > {1'b0, col})
				tab_c = 8'(k * TAB_WIDTH);
		end
	end

	always_comb begin
		c       = {1'b0, col};
		r       = {1'b0, row};
		wr_en   = 1'b0;
		wr_addr = cell_addr({1'b0, row}, {1'b0, col});
		wr_val  = blank;
		sc_en   = 1'b0;
		sc_kind = KIND_SCROLL;
		sc_addr = cell_addr(6'(ROWS - 1), 8'd0);
		case (cmd.func)
			FUNC_PUT: begin
				case (cmd.char_code)
					CH_BS: begin
						if (col != 7'd0) begin
							c       = {1'b0, col} - 8'd1;
							wr_en   = 1'b1;
							wr_addr = cell_addr(r, c);
						end else if (row != 5'd0) begin
							c       = 8'(COLUMNS - 1);
							r       = {1'b0, row} - 6'd1;
							wr_en   = 1'b1;
							wr_addr = cell_addr(r, c);
						end
					end
					CH_TAB: c = tab_c;
					CH_CR:  c = '0;
					CH_LF: begin
						c = '0;
						r = {1'b0, row} + 6'd1;
					end
					default: begin
						if (cmd.char_code inside {[CH_SPACE:CH_DEL]}) begin
							wr_en  = 1'b1;
							wr_val = {attr, cmd.char_code};
							c      = {1'b0, col} + 8'd1;
						end
					end
				endcase
				if (c >= 8'(COLUMNS)) begin
					c = '0;
					r = r + 6'd1;
				end
				if (r >= 6'(ROWS)) begin
					sc_en = 1'b1;
					r     = 6'(ROWS - 1);
				end
			end
			FUNC_SET: begin
				c = ({1'b0, cmd.new_col} < 8'(COLUMNS)) ? {1'b0, cmd.new_col} : 8'(COLUMNS - 1);
				r = ({1'b0, cmd.new_row} < 6'(ROWS)) ? {1'b0, cmd.new_row} : 6'(ROWS - 1);
			end
			FUNC_CLEAR: begin
				sc_en   = 1'b1;
				sc_kind = KIND_CLEAR;
				sc_addr = '0;
				c       = '0;
				r       = '0;
			end
			default: ;
		endcase
	end

	assign next_col = c[6:0];
	assign next_row = r[4:0];

	always_comb begin
		bundle.valid = {cmd.func != FUNC_NONE, sc_en, wr_en};
		bundle.slot[0] = '{KIND_WRITE, wr_addr, wr_val, c[6:0], r[4:0], 1'b0};
		bundle.slot[1] = '{sc_kind, sc_addr, blank, c[6:0], r[4:0], 1'b0};
		bundle.slot[2] = '{KIND_CURSOR, cell_addr(r, c), 16'd0, c[6:0], r[4:0], 1'b1};
	end

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine.
// Holds cursor, attribute, pending results and the output register.
// Depends on tcce_pkg and tcce_decode.

// A command is decoded in the cycle it is taken and leaves up to three
// results (cell write, scroll or clear, cursor update), which go out one
// per cycle through a registered output while the receiver does not stall.
// The next command is taken in the same cycle as the last result of the
// previous one moves to the output. A plain cursor move gives only the
// cursor update; a command that writes a cell, scrolls or clears adds that
// result, and a character that writes and scrolls gives all three.
// Function code 3 gives no result.
module text_console_cursor_engine import tcce_pkg::*; #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res,
	input  logic       attr_we,
	input  logic [7:0] attr_wdata
);

	logic [7:0] attr_q;
	logic [6:0] col_q;
	logic [4:0] row_q;
	logic [2:0] valid_s1;
	res_t [2:0] slot_s1;
	res_t       res_q;
	logic       res_valid_q;

	bundle_t    dec;
	logic [6:0] dec_col;
	logic [4:0] dec_row;
	logic [2:0] pop_mask;
	logic [1:0] pop_idx;
	logic       load_out;
	logic       take;

	tcce_decode #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_decode (
		.cmd     (cmd),
		.col     (col_q),
		.row     (row_q),
		.attr    (attr_q),
		.bundle  (dec),
		.next_col(dec_col),
		.next_row(dec_row)
	);

	always_comb begin
		pop_idx = 2'd2;
		if (valid_s1[0])
			pop_idx = 2'd0;
		else if (valid_s1[1])
			pop_idx = 2'd1;
	end

	assign load_out  = (|valid_s1) && (!res_valid_q || !res_stall);
	assign pop_mask  = load_out ? (3'b001 << pop_idx) : 3'b000;
	assign cmd_stall = |(valid_s1 & ~pop_mask);
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (attr_we)
				attr_q <= attr_wdata;
			if (take) begin
				col_q    <= dec_col;
				row_q    <= dec_row;
				valid_s1 <= dec.valid;
			end else begin
				valid_s1 <= valid_s1 & ~pop_mask;
			end
			if (load_out)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			slot_s1 <= dec.slot;
		if (load_out)
			res_q <= slot_s1[pop_idx];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/tcce_check.sv =====
// Port checks for the text console cursor engine, bound to the top level.
// Result ordering and content rules seen on the result transfer.
// Depends on tcce_pkg.
module tcce_check import tcce_pkg::*; #(
	parameter int COLUMNS = 80
) (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	logic [31:0] cur_addr;
	assign cur_addr = 32'(res.cursor_row_out) * 32'(COLUMNS) + 32'(res.cursor_col_out);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_last_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.last == (res.kind != KIND_CURSOR)) |-> 1'b0)
		else $error("last flag and cursor update disagree");

	a_cursor_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_CURSOR |->
			res.cell_address == cur_addr[ADDR_W-1:0] && res.cell_value == 16'd0)
		else $error("cursor update address does not match cursor");

	a_blank_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_SCROLL || res.kind == KIND_CLEAR) |->
			res.cell_value[7:0] == CH_SPACE)
		else $error("scroll or clear without blank fill");

	// within one command the cursor fields do not change
	a_same_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res.last ##1 res_valid |->
			res.cursor_col_out == $past(res.cursor_col_out) &&
			res.cursor_row_out == $past(res.cursor_row_out))
		else $error("cursor changed within one command");

endmodule

bind text_console_cursor_engine tcce_check #(.COLUMNS(COLUMNS)) u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for text_console_cursor_engine: drives command transfers,
// predicts the display operations of each command and checks every result transfer.
// Depends on tcce_pkg and the RTL of the block.
module tb_top;
	import tcce_pkg::*;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 60;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	cmd_t       cmd;
	logic       res_valid;
	logic       res_stall;
	res_t       res;
	logic       attr_we;
	logic [7:0] attr_wdata;

	// console shadow state
	int         cur_col;
	int         cur_row;
	logic [7:0] cur_attr;

	res_t due_ops[$];

	bit src_idle;
	bit sink_idle;
	bit long_hold_req;
	int stall_left;
	int cycles;
	int n_mism;
	int n_cmds;
	int n_results;
	int n_scrolls;
	int n_clears;
	int n_attr_writes;

	text_console_cursor_engine #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.attr_we   (attr_we),
		.attr_wdata(attr_wdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic res_t make_op(kind_t k, int addr, logic [15:0] val);
		res_t r;
		r = '0;
		r.kind = k;
		r.cell_address = ADDR_W'(addr);
		r.cell_value = val;
		return r;
	endfunction

	function automatic cmd_t make_cmd(func_t f, logic [7:0] code, logic [6:0] col,
			logic [4:0] row);
		cmd_t c;
		c.func = f;
		c.char_code = code;
		c.new_col = col;
		c.new_row = row;
		return c;
	endfunction

	// Works out the display operations of one command and queues them.
	task automatic track_console(input cmd_t c);
		res_t ops[$];
		res_t r;
		int col;
		int row;
		logic [15:0] blank;
		col = cur_col;
		row = cur_row;
		blank = {cur_attr, CH_SPACE};
		if (c.func == FUNC_NONE)
			return;
		case (c.func)
			FUNC_PUT: begin
				if (c.char_code == CH_BS) begin
					if (col > 0) begin
						col--;
						ops.push_back(make_op(KIND_WRITE, row * COLUMNS + col, blank));
					end else if (row > 0) begin
						col = COLUMNS - 1;
						row--;
						ops.push_back(make_op(KIND_WRITE, row * COLUMNS + col, blank));
					end
				end else if (c.char_code == CH_TAB) begin
					col = (col / TAB_WIDTH + 1) * TAB_WIDTH;
				end else if (c.char_code == CH_CR) begin
					col = 0;
				end else if (c.char_code == CH_LF) begin
					col = 0;
					row++;
				end else if (c.char_code >= CH_SPACE && c.char_code <= CH_DEL) begin
					ops.push_back(make_op(KIND_WRITE, row * COLUMNS + col,
						{cur_attr, c.char_code}));
					col++;
				end
				if (col >= COLUMNS) begin
					col = 0;
					row++;
				end
				if (row >= ROWS) begin
					ops.push_back(make_op(KIND_SCROLL, (ROWS - 1) * COLUMNS, blank));
					row = ROWS - 1;
				end
			end
			FUNC_SET: begin
				col = (int'(c.new_col) < COLUMNS) ? int'(c.new_col) : COLUMNS - 1;
				row = (int'(c.new_row) < ROWS) ? int'(c.new_row) : ROWS - 1;
			end
			default: begin
				ops.push_back(make_op(KIND_CLEAR, 0, blank));
				col = 0;
				row = 0;
			end
		endcase
		ops.push_back(make_op(KIND_CURSOR, row * COLUMNS + col, 16'h0000));
		foreach (ops[i]) begin
			r = ops[i];
			r.cursor_col_out = 7'(col);
			r.cursor_row_out = 5'(row);
			r.last = (i == ops.size() - 1);
			due_ops.push_back(r);
		end
		cur_col = col;
		cur_row = row;
	endtask

	// One command transfer; returns just after the accepting edge.
	task automatic send_cmd(input cmd_t c);
		int gap;
		@(negedge clk);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		track_console(c);
		n_cmds++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (due_ops.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attr(input logic [7:0] val);
		wait_idle();
		@(negedge clk);
		attr_we <= 1'b1;
		attr_wdata <= val;
		@(negedge clk);
		attr_we <= 1'b0;
		attr_wdata <= 8'($urandom);
		cur_attr = val;
		n_attr_writes++;
	endtask

	function automatic cmd_t pick_cmd();
		cmd_t c;
		int sel;
		c = make_cmd(FUNC_PUT, 8'($urandom), 7'($urandom), 5'($urandom));
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			c.char_code = 8'($urandom_range(32, 127));
		end else if (sel < 70) begin
			case ($urandom_range(0, 3))
				0: c.char_code = CH_BS;
				1: c.char_code = CH_TAB;
				2: c.char_code = CH_CR;
				default: c.char_code = CH_LF;
			endcase
		end else if (sel < 76) begin
			// any byte, mostly ignored codes
		end else if (sel < 90) begin
			c.func = FUNC_SET;
			if ($urandom_range(0, 1) == 1) begin
				c.new_col = 7'($urandom_range(70, 79));
				c.new_row = 5'($urandom_range(22, 24));
			end
		end else if (sel < 94) begin
			c.func = FUNC_CLEAR;
		end else begin
			c.func = FUNC_NONE;
		end
		return c;
	endfunction

	// receiver stall bursts and the long hold-off
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			res_stall <= 1'b1;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = LONG_HOLD - 1;
			res_stall <= 1'b1;
		end else if (sink_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : res_check
		res_t want;
		res_t got;
		bit bad;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			got = res;
			n_results++;
			if (got.kind == KIND_SCROLL)
				n_scrolls++;
			if (got.kind == KIND_CLEAR)
				n_clears++;
			if (due_ops.size() == 0) begin
				n_mism++;
				if (n_mism <= 10)
					$display("unexpected result: kind %0d addr %0d value %h col %0d row %0d last %0b",
						got.kind, got.cell_address, got.cell_value, got.cursor_col_out,
						got.cursor_row_out, got.last);
			end else begin
				want = due_ops.pop_front();
				bad = (got.kind !== want.kind)
					|| (got.cell_address !== want.cell_address)
					|| (got.cell_value !== want.cell_value)
					|| (got.cursor_col_out !== want.cursor_col_out)
					|| (got.cursor_row_out !== want.cursor_row_out)
					|| (got.last !== want.last);
				if (bad) begin
					n_mism++;
					if (n_mism <= 10) begin
						$display("mismatch: exp kind %0d addr %0d value %h col %0d row %0d last %0b",
							want.kind, want.cell_address, want.cell_value,
							want.cursor_col_out, want.cursor_row_out, want.last);
						$display("          got kind %0d addr %0d value %h col %0d row %0d last %0b",
							got.kind, got.cell_address, got.cell_value,
							got.cursor_col_out, got.cursor_row_out, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("text_console_cursor_engine regression: fail");
			$finish;
		end
	end

	task automatic test_directed();
		send_cmd(make_cmd(FUNC_PUT, 8'h41, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_SET, 8'hFF, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_PUT, CH_BS, 7'h7F, 5'h1F));
		send_cmd(make_cmd(FUNC_PUT, CH_DEL, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_SPACE, 7'h7F, 5'h1F));
		send_cmd(make_cmd(FUNC_PUT, 8'h00, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, 8'hFF, 7'h7F, 5'h1F));
		send_cmd(make_cmd(FUNC_PUT, 8'h80, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, 8'h1F, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_BS, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_TAB, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_CR, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_LF, 7'h00, 5'h00));
		// saturating position, then a character in the last cell scrolls
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'h7F, 5'h1F));
		send_cmd(make_cmd(FUNC_PUT, 8'h5A, 7'h00, 5'h00));
		// backspace wrapping to the row above
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd0, 5'd5));
		send_cmd(make_cmd(FUNC_PUT, CH_BS, 7'h00, 5'h00));
		// tab off the end of the bottom row
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd72, 5'd24));
		send_cmd(make_cmd(FUNC_PUT, CH_TAB, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_LF, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_PUT, CH_CR, 7'h00, 5'h00));
		send_cmd(make_cmd(FUNC_CLEAR, 8'hFF, 7'h7F, 5'h1F));
		send_cmd(make_cmd(FUNC_NONE, 8'hFF, 7'h7F, 5'h1F));
		send_cmd(make_cmd(FUNC_PUT, 8'h7E, 7'h00, 5'h00));
	endtask

	task automatic test_attributes();
		logic [7:0] settings [4];
		settings[0] = 8'h00;
		settings[1] = 8'hFF;
		settings[2] = 8'hA5;
		settings[3] = 8'($urandom);
		foreach (settings[i]) begin
			write_attr(settings[i]);
			repeat (8) send_cmd(pick_cmd());
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		long_hold_req = 1'b1;
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd70, 5'd24));
		repeat (14) send_cmd(make_cmd(FUNC_PUT, 8'($urandom_range(32, 127)), 7'h00, 5'h00));
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_random(input int count);
		cmd_t c;
		int done;
		done = 0;
		while (done < count) begin
			if (done == count - 60) begin
				src_idle = 1'b0;
				sink_idle = 1'b0;
			end
			c = pick_cmd();
			send_cmd(c);
			if (c.func != FUNC_NONE)
				done++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		attr_we = 1'b0;
		attr_wdata = 8'h00;
		cur_col = 0;
		cur_row = 0;
		cur_attr = ATTR_RESET;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		long_hold_req = 1'b0;
		stall_left = 0;
		cycles = 0;
		n_mism = 0;
		n_cmds = 0;
		n_results = 0;
		n_scrolls = 0;
		n_clears = 0;
		n_attr_writes = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_attributes();
		test_backpressure();
		write_attr(8'h1E);
		test_random(440);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("covered %0d commands giving %0d results (%0d scrolls, %0d clears)",
			n_cmds, n_results, n_scrolls, n_clears);
		$display("with %0d attribute settings and %0d mismatches", n_attr_writes, n_mism);
		if (n_mism == 0 && due_ops.size() == 0) begin
			$display("text_console_cursor_engine regression: pass");
		end else begin
			$display("text_console_cursor_engine regression: fail");
		end
		$finish;
	end

endmodule

// ===== text_console_cursor_engine.f =====
hdl/tcce_pkg.sv
hdl/tcce_decode.sv
hdl/text_console_cursor_engine.sv
hdl/tcce_check.sv
tb/tb_top.sv
